### rtl/tfd_pkg.sv
// Package with the frame constants and shared types of the telemetry frame decoder.
`default_nettype none

package tfd_pkg;

  // Frame marker bytes.
  localparam logic [7:0] SYNC_BYTE  = 8'h16;
  localparam logic [7:0] START_BYTE = 8'h53;
  localparam logic [7:0] NEG_MARK   = 8'h10;

  // Payload widths of the result fields.
  localparam int TEMP_W   = 9;
  localparam int BYTE_W   = 8;
  localparam int POWER_W  = 16;
  localparam int OUT_BITS = TEMP_W + 3 * BYTE_W + POWER_W;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  // Body positions are compared at a fixed width that covers the longest body.
  localparam int POS_W = 6;
  localparam logic [POS_W-1:0] POS_SIGN     = 6'd1;
  localparam logic [POS_W-1:0] POS_TEMP     = 6'd2;
  localparam logic [POS_W-1:0] POS_HUMIDITY = 6'd3;
  localparam logic [POS_W-1:0] POS_SHOCK    = 6'd4;
  localparam logic [POS_W-1:0] POS_FAN      = 6'd5;
  localparam logic [POS_W-1:0] POS_POWER_HI = 6'd6;
  localparam logic [POS_W-1:0] POS_POWER_LO = 6'd7;

  // Frame parser state.
  typedef enum logic [2:0] {
    PH_HUNT  = 3'b001,
    PH_START = 3'b010,
    PH_BODY  = 3'b100
  } phase_t;

endpackage : tfd_pkg

`default_nettype wire

### rtl/telemetry_frame_decoder_unit.sv
// Top level of the telemetry frame decoder: byte parser, field holds and result register.
//
// The in_ channel carries one received serial byte per transfer. The parser hunts for
// the sync byte 0x16, then requires 0x53 as the next byte (any other byte is dropped and
// hunting resumes with the byte after it), then collects a body of BODY_LENGTH bytes.
// Bytes inside a body are data only and are never taken as sync bytes.
// The out_ channel carries one decoded result per complete frame. The result is loaded
// into the output register at the edge that takes the last body byte and is shown on
// out_tvalid in the cycle after the transfer of that byte.
// Throughput is one byte per cycle while in_tready is high: all per-byte work is a compare
// and a field select between the parser state registers and the result register.
// While a result waits on out_tready, bytes keep being taken; only the last body byte of
// the next frame is held off (in_tready low) until the waiting result has been taken.
// A frame is two header bytes and BODY_LENGTH body bytes long, so this stall occurs only
// when a result is still waiting as the last body byte of the next frame arrives.
// A synchronous active-low reset returns the parser to hunting and empties the result
// register; the field holds need no reset since each frame rewrites all of them.
`default_nettype none

module telemetry_frame_decoder_unit #(
  parameter int BODY_LENGTH = 8
) (
  input  wire                      clk,
  input  wire                      rst_n,
  // Input channel.
  input  wire                      in_tvalid,
  output logic                     in_tready,
  input  wire  [7:0]               in_tdata,   // [7:0] rx_byte
  // Result channel.
  output logic                     out_tvalid,
  input  wire                      out_tready,
  // [8:0] temperature (signed), [16:9] humidity, [24:17] shock,
  // [32:25] fan_state, [48:33] power_reading, upper bits zero.
  output logic [tfd_pkg::OUT_W-1:0] out_tdata
);

  localparam int IDX_W = (BODY_LENGTH > 1) ? $clog2(BODY_LENGTH) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BODY_LENGTH - 1);

  // Parser state.
  tfd_pkg::phase_t  phase_r, phase_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;

  // Field holds; each frame overwrites all of them before its result is taken.
  logic        neg_r, neg_nxt;
  logic [7:0]  mag_r, mag_nxt;
  logic [7:0]  hum_r, hum_nxt;
  logic [7:0]  shock_r, shock_nxt;
  logic [7:0]  fan_r, fan_nxt;
  logic [15:0] power_r, power_nxt;

  // Result register.
  logic                       out_valid_r;
  logic [tfd_pkg::OUT_W-1:0]  out_data_r, out_data_nxt;

  logic                          in_xfer;
  logic                          last_slot;
  logic [tfd_pkg::POS_W-1:0]     body_pos;
  logic [tfd_pkg::TEMP_W-1:0]    temp_val;

  // The only byte that produces a result is the last body byte, known from state alone.
  assign last_slot = (phase_r == tfd_pkg::PH_BODY) && (idx_r == LAST_IDX);
  assign in_tready = !(last_slot && out_valid_r && !out_tready);
  assign in_xfer   = in_tvalid && in_tready;
  assign body_pos  = tfd_pkg::POS_W'(idx_r);

  // Next parser state and field holds for the byte on the input.
  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    neg_nxt   = neg_r;
    mag_nxt   = mag_r;
    hum_nxt   = hum_r;
    shock_nxt = shock_r;
    fan_nxt   = fan_r;
    power_nxt = power_r;
    unique case (phase_r)
      tfd_pkg::PH_START: begin
        idx_nxt = '0;
        if (in_tdata == tfd_pkg::START_BYTE) begin
          phase_nxt = tfd_pkg::PH_BODY;
        end else begin
          phase_nxt = tfd_pkg::PH_HUNT;
        end
      end
      tfd_pkg::PH_BODY: begin
        case (body_pos)
          tfd_pkg::POS_SIGN:     neg_nxt         = (in_tdata == tfd_pkg::NEG_MARK);
          tfd_pkg::POS_TEMP:     mag_nxt         = in_tdata;
          tfd_pkg::POS_HUMIDITY: hum_nxt         = in_tdata;
          tfd_pkg::POS_SHOCK:    shock_nxt       = in_tdata;
          tfd_pkg::POS_FAN:      fan_nxt         = in_tdata;
          tfd_pkg::POS_POWER_HI: power_nxt[15:8] = in_tdata;
          tfd_pkg::POS_POWER_LO: power_nxt[7:0]  = in_tdata;
          default: ;
        endcase
        if (idx_r == LAST_IDX) begin
          phase_nxt = tfd_pkg::PH_HUNT;
          idx_nxt   = '0;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      default: begin
        // Hunting; an unexpected phase code behaves the same way.
        if (in_tdata == tfd_pkg::SYNC_BYTE) begin
          phase_nxt = tfd_pkg::PH_START;
        end else begin
          phase_nxt = tfd_pkg::PH_HUNT;
        end
      end
    endcase
  end

  // The result sees the holds as updated by the last body byte itself.
  always_comb begin
    temp_val = neg_nxt ? (9'd0 - {1'b0, mag_nxt}) : {1'b0, mag_nxt};
    out_data_nxt = tfd_pkg::OUT_W'({power_nxt, fan_nxt, shock_nxt, hum_nxt, temp_val});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= tfd_pkg::PH_HUNT;
      idx_r   <= '0;
    end else if (in_xfer) begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      neg_r   <= neg_nxt;
      mag_r   <= mag_nxt;
      hum_r   <= hum_nxt;
      shock_r <= shock_nxt;
      fan_r   <= fan_nxt;
      power_r <= power_nxt;
    end
  end

  // Output register: loaded on the last body byte, emptied when the receiver takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer && last_slot) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && last_slot) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule : telemetry_frame_decoder_unit

`default_nettype wire

### rtl/tfd_checker.sv
// Port-level checker for the telemetry frame decoder and its bind statement.
`default_nettype none

module tfd_checker (
  input wire                      clk,
  input wire                      rst_n,
  input wire                      out_tvalid,
  input wire                      out_tready,
  input wire [tfd_pkg::OUT_W-1:0] out_tdata
);

  // A stalled result stays offered.
  a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result payload changed while stalled");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result offered right after reset");

  // A temperature is a negated or plain byte, never -256.
  a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[8:0] != 9'h100)
    else $error("temperature out of range");

  // Padding bits above the packed fields stay zero.
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[tfd_pkg::OUT_W-1:tfd_pkg::OUT_BITS] == '0)
    else $error("padding bits set in result");

endmodule : tfd_checker

bind telemetry_frame_decoder_unit tfd_checker u_tfd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

### verif/testbench.sv
// Self-checking testbench for the telemetry frame decoder with a frame predictor.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BODY_LEN      = 8;
  localparam int WATCHDOG_IDLE = 1000;
  localparam int FRAME_BYTES   = 500;
  localparam int DRAIN_CYCLES  = 8;

  // One decoded frame as it leaves the out_ channel.
  typedef struct {
    logic signed [tfd_pkg::TEMP_W-1:0] temperature;
    logic [tfd_pkg::BYTE_W-1:0]        humidity;
    logic [tfd_pkg::BYTE_W-1:0]        shock;
    logic [tfd_pkg::BYTE_W-1:0]        fan_state;
    logic [tfd_pkg::POWER_W-1:0]       power_reading;
  } reading_t;

  // Follows the parser byte by byte and keeps the readings that are still owed.
  class frame_tracker;
    tfd_pkg::phase_t           parse_phase;
    logic [tfd_pkg::POS_W-1:0] body_pos;
    bit                        negative;
    logic [7:0]                temp_mag;
    logic [7:0]                hum_hold;
    logic [7:0]                shock_hold;
    logic [7:0]                fan_hold;
    logic [15:0]               power_hold;
    reading_t                  owed_readings[$];
    int                        mismatches;
    int                        bytes_taken;
    int                        frames_checked;
    int                        negative_frames;

    function new();
      parse_phase = tfd_pkg::PH_HUNT;
      body_pos    = '0;
      negative    = 1'b0;
      temp_mag    = '0;
      hum_hold    = '0;
      shock_hold  = '0;
      fan_hold    = '0;
      power_hold  = '0;
    endfunction

    function int pending();
      return owed_readings.size();
    endfunction

    // Advance the frame parser by one accepted byte.
    function void note_byte(logic [7:0] rx);
      reading_t r;
      bytes_taken++;
      case (parse_phase)
        tfd_pkg::PH_START: begin
          if (rx == tfd_pkg::START_BYTE) begin
            parse_phase = tfd_pkg::PH_BODY;
            body_pos    = '0;
          end else begin
            // The byte after a sync is dropped without a second look.
            parse_phase = tfd_pkg::PH_HUNT;
          end
        end
        tfd_pkg::PH_BODY: begin
          // Body bytes are data only, even when they look like markers.
          case (body_pos)
            tfd_pkg::POS_SIGN:     negative = (rx == tfd_pkg::NEG_MARK);
            tfd_pkg::POS_TEMP:     temp_mag = rx;
            tfd_pkg::POS_HUMIDITY: hum_hold = rx;
            tfd_pkg::POS_SHOCK:    shock_hold = rx;
            tfd_pkg::POS_FAN:      fan_hold = rx;
            tfd_pkg::POS_POWER_HI: power_hold[15:8] = rx;
            tfd_pkg::POS_POWER_LO: power_hold[7:0] = rx;
            default: ;
          endcase
          if (int'(body_pos) + 1 >= BODY_LEN) begin
            r.temperature   = negative ? -$signed({1'b0, temp_mag})
                                       : $signed({1'b0, temp_mag});
            r.humidity      = hum_hold;
            r.shock         = shock_hold;
            r.fan_state     = fan_hold;
            r.power_reading = power_hold;
            owed_readings.push_back(r);
            if (negative) negative_frames++;
            parse_phase = tfd_pkg::PH_HUNT;
            body_pos    = '0;
          end else begin
            body_pos = body_pos + tfd_pkg::POS_W'(1);
          end
        end
        default: parse_phase = (rx == tfd_pkg::SYNC_BYTE) ? tfd_pkg::PH_START
                                                          : tfd_pkg::PH_HUNT;
      endcase
    endfunction

    function void compare_field(string label, longint want, longint got);
      if (want != got) begin
        mismatches++;
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
      end
    endfunction

    // Compare one result transfer with the oldest owed reading.
    function void check_result(logic [tfd_pkg::OUT_W-1:0] word);
      reading_t want;
      if (owed_readings.size() == 0) begin
        mismatches++;
        $display("%0t ns: result %h arrived with no frame outstanding", $time, word);
        return;
      end
      want = owed_readings.pop_front();
      frames_checked++;
      compare_field("temperature", want.temperature, $signed(word[8:0]));
      compare_field("humidity", want.humidity, word[16:9]);
      compare_field("shock", want.shock, word[24:17]);
      compare_field("fan_state", want.fan_state, word[32:25]);
      compare_field("power_reading", want.power_reading, word[48:33]);
      compare_field("padding", 0, word[tfd_pkg::OUT_W-1:49]);
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_tvalid = 1'b0;
  logic [7:0]                in_tdata = 8'h00;
  logic                      out_tready = 1'b0;
  wire                       in_tready;
  wire                       out_tvalid;
  wire [tfd_pkg::OUT_W-1:0]  out_tdata;

  frame_tracker tracker;
  bit           calm = 1'b0;
  int           frame_bytes_sent = 0;
  int           broken_headers = 0;
  int           idle_cycles = 0;

  telemetry_frame_decoder_unit #(.BODY_LENGTH(BODY_LEN)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Random byte that lands on the marker values fairly often.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0:       return tfd_pkg::SYNC_BYTE;
      1:       return tfd_pkg::START_BYTE;
      2:       return tfd_pkg::NEG_MARK;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Drive one byte, hold it until the transfer, then idle for a random gap.
  task automatic send_byte(input logic [7:0] rx);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= rx;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_frame(input logic [7:0] lead, input logic [7:0] sign,
                            input logic [7:0] mag, input logic [7:0] hum,
                            input logic [7:0] shk, input logic [7:0] fan,
                            input logic [15:0] pwr);
    send_byte(tfd_pkg::SYNC_BYTE);
    send_byte(tfd_pkg::START_BYTE);
    send_byte(lead);
    send_byte(sign);
    send_byte(mag);
    send_byte(hum);
    send_byte(shk);
    send_byte(fan);
    send_byte(pwr[15:8]);
    send_byte(pwr[7:0]);
    frame_bytes_sent += 2 + BODY_LEN;
  endtask

  task automatic send_random_frame();
    logic [7:0] sign;
    sign = ($urandom_range(0, 1) == 0) ? tfd_pkg::NEG_MARK : pick_byte();
    send_frame(pick_byte(), sign, pick_byte(), pick_byte(),
               ($urandom_range(0, 3) == 0) ? 8'h01 : pick_byte(), pick_byte(),
               {pick_byte(), pick_byte()});
  endtask

  // Result side: bursts of ready with random stalls, always ready in calm stretches.
  initial begin : result_sink
    int stall;
    forever begin
      out_tready <= 1'b1;
      if (calm) begin
        @(posedge clk);
      end else begin
        repeat ($urandom_range(1, 6)) @(posedge clk);
        stall = pick_gap();
        if (stall > 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
    end
  end

  // Both channels are sampled at the clock edge, before any driver update lands.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) tracker.note_byte(in_tdata);
      if (out_tvalid && out_tready) tracker.check_result(out_tdata);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_IDLE) begin
        $display("%0t ns: no transfer for %0d cycles, run stopped", $time, idle_cycles);
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int kind;
    bit drained_once;
    drained_once = 1'b0;
    tracker = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: field extremes, a bad second byte, markers inside a body.
    send_frame(tfd_pkg::SYNC_BYTE, tfd_pkg::NEG_MARK, 8'hFF, 8'h00, 8'h01, 8'hFF, 16'hFF00);
    send_byte(tfd_pkg::SYNC_BYTE);
    send_byte(tfd_pkg::SYNC_BYTE);
    send_byte(tfd_pkg::START_BYTE);
    send_frame(tfd_pkg::START_BYTE, tfd_pkg::SYNC_BYTE, 8'h80, tfd_pkg::SYNC_BYTE,
               tfd_pkg::START_BYTE, 8'h00, 16'h00FF);

    // Random part: mostly well-formed frames, some noise and broken headers.
    while (frame_bytes_sent < FRAME_BYTES) begin
      calm = ($urandom_range(0, 5) == 0);
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        send_random_frame();
      end else if (kind == 7) begin
        repeat ($urandom_range(1, 4)) send_byte(pick_byte());
      end else if (kind == 8) begin
        send_byte(tfd_pkg::SYNC_BYTE);
        send_byte(($urandom_range(0, 1) == 0) ? tfd_pkg::SYNC_BYTE
                                              : 8'($urandom_range(0, 82)));
        broken_headers++;
      end else begin
        send_byte(tfd_pkg::SYNC_BYTE);
        send_byte(8'($urandom_range(84, 255)));
        send_byte(tfd_pkg::START_BYTE);
        broken_headers++;
      end
      // Once midway, hold the input until every owed reading has come out.
      if (!drained_once && frame_bytes_sent >= FRAME_BYTES / 2) begin
        drained_once = 1'b1;
        in_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(posedge clk);
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b0;
    calm = 1'b0;

    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.pending() != 0) begin
      tracker.mismatches++;
      $display("%0t ns: %0d readings never arrived", $time, tracker.pending());
    end

    $display("Run covered %0d bytes, %0d decoded frames (%0d with negative temperature),",
             tracker.bytes_taken, tracker.frames_checked, tracker.negative_frames);
    $display("and %0d broken headers among random noise, with gaps on both channels.",
             broken_headers);
    if (tracker.mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
